// ----- rtl/modular_exponentiation_macros.svh -----
// Assertion macros for the checker file of the modular exponentiation block.
// No dependencies; every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Clocked assertion with reset disable and an error report.
`define MEXP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Assertion that a condition never holds.
`define MEXP_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/mexp_pkg.sv -----
// Package of the modular exponentiation block: widths, operation codes and the
// command and status structs between controller and datapath. No dependencies.
package mexp_pkg;

    localparam int WORD_BITS_DEF = 64;
    localparam int FIELD_W       = 63;
    localparam int DATA_W        = 64;
    localparam int CNT_W         = 6;
    localparam int IN_TDATA_W    = 192;

    typedef enum logic [1:0] {
        OP_SQUARE = 2'b01,
        OP_MULT   = 2'b10
    } t_op;

    typedef struct packed {
        logic load;
        logic start;
        t_op  op;
        logic shift_exp;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic exp_msb;
    } t_status;

endpackage

// ----- rtl/modular_exponentiation.sv -----
// Modular exponentiation top level: one transaction in, base^exponent out.
// From input accept to result valid, the controller runs a base reduction, then a square
// for each of the 63 exponent bits and a multiply for each one bit, on one bit-serial
// multiplier. One transaction at a time; the next can be accepted in the cycle after the
// result is taken. Reset (synchronous, active low) idles the controller and clears the
// datapath flags.
module modular_exponentiation #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // base_value [62:0], exponent_value [125:63], modulus_value [188:126], zero fill
    input  logic [mexp_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // power_result [63:0]
    output logic [mexp_pkg::DATA_W-1:0]      m_tdata
);

    mexp_pkg::t_cmd    cmd;
    mexp_pkg::t_status status;

    mexp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mexp_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_base   (s_tdata[62:0]),
        .i_exp    (s_tdata[125:63]),
        .i_mod    (s_tdata[188:126]),
        .o_status (status),
        .o_result (m_tdata)
    );

    logic unused_pad;
    assign unused_pad = ^s_tdata[mexp_pkg::IN_TDATA_W-1:189];

endmodule

// ----- rtl/mexp_datapath.sv -----
// Datapath of the modular exponentiation block: operand registers and a bit-serial
// shift-add multiplier with modular reduction. Depends on mexp_pkg.
module mexp_datapath #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mexp_pkg::t_cmd               i_cmd,
    input  logic [mexp_pkg::FIELD_W-1:0] i_base,
    input  logic [mexp_pkg::FIELD_W-1:0] i_exp,
    input  logic [mexp_pkg::FIELD_W-1:0] i_mod,
    output mexp_pkg::t_status            o_status,
    output logic [mexp_pkg::DATA_W-1:0]  o_result
);

    localparam logic [mexp_pkg::DATA_W-1:0] WordMask =
        mexp_pkg::DATA_W'({mexp_pkg::DATA_W{1'b1}} >> (mexp_pkg::DATA_W - WORD_BITS));

    logic                          r_busy, r_done;
    logic [mexp_pkg::CNT_W-1:0]    r_cnt;
    logic [mexp_pkg::DATA_W-1:0]   r_x, r_y, r_prod, r_acc, r_base;
    logic [mexp_pkg::FIELD_W-1:0]  r_exp, r_mod;
    logic                          r_mod_nz, r_exp_zero, r_dest_base;
    logic [mexp_pkg::DATA_W-1:0]   mod_ext, n_dbl, n_prod, n_sum, n_final, one_val;

    assign mod_ext = {1'b0, r_mod};
    assign one_val = (i_mod == mexp_pkg::FIELD_W'(1)) ? '0 : mexp_pkg::DATA_W'(1);

    always_comb begin
        n_dbl = {r_prod[mexp_pkg::DATA_W-2:0], 1'b0};
        if (r_mod_nz && n_dbl >= mod_ext) begin
            n_dbl = n_dbl - mod_ext;
        end
        n_sum = r_y[mexp_pkg::DATA_W-1] ? n_dbl + r_x : n_dbl;
        n_prod = n_sum;
        if (r_mod_nz && n_sum >= mod_ext) begin
            n_prod = n_sum - mod_ext;
        end
        n_final = r_mod_nz ? n_prod : (n_prod & WordMask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.load || i_cmd.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x         <= one_val;
            r_acc       <= one_val;
            r_y         <= {1'b0, i_base};
            r_prod      <= '0;
            r_cnt       <= '1;
            r_dest_base <= 1'b1;
            r_exp       <= i_exp;
            r_mod       <= i_mod;
            r_mod_nz    <= (i_mod != '0);
            r_exp_zero  <= (i_exp == '0);
        end else if (i_cmd.start) begin
            r_x         <= r_acc;
            r_y         <= (i_cmd.op == mexp_pkg::OP_SQUARE) ? r_acc : r_base;
            r_prod      <= '0;
            r_cnt       <= '1;
            r_dest_base <= 1'b0;
        end else if (r_busy) begin
            r_prod <= n_prod;
            r_y    <= {r_y[mexp_pkg::DATA_W-2:0], 1'b0};
            r_cnt  <= r_cnt - mexp_pkg::CNT_W'(1);
            if (r_cnt == '0) begin
                if (r_dest_base) begin
                    r_base <= n_final;
                end else begin
                    r_acc <= n_final;
                end
            end
        end
        if (i_cmd.shift_exp) begin
            r_exp <= {r_exp[mexp_pkg::FIELD_W-2:0], 1'b0};
        end
    end

    assign o_status.done    = r_done;
    assign o_status.exp_msb = r_exp[mexp_pkg::FIELD_W-1];
    assign o_result = r_exp_zero ? mexp_pkg::DATA_W'(1) : r_acc;

endmodule

// ----- rtl/mexp_ctrl.sv -----
// Controller of the modular exponentiation block: walks the exponent bits and
// sequences square and multiply operations. Depends on mexp_pkg.
module mexp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  mexp_pkg::t_status i_status,
    output mexp_pkg::t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RED  = 5'b00010,
        S_SQR  = 5'b00100,
        S_MUL  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                     r_state, n_state;
    logic [mexp_pkg::CNT_W-1:0] r_bit, n_bit;

    always_comb begin
        n_state         = r_state;
        n_bit           = r_bit;
        o_cmd.load      = 1'b0;
        o_cmd.start     = 1'b0;
        o_cmd.op        = mexp_pkg::OP_SQUARE;
        o_cmd.shift_exp = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RED;
                end
            end
            S_RED: begin
                if (i_status.done) begin
                    o_cmd.start = 1'b1;
                    n_bit       = mexp_pkg::CNT_W'(mexp_pkg::FIELD_W - 1);
                    n_state     = S_SQR;
                end
            end
            S_SQR, S_MUL: begin
                if (i_status.done) begin
                    if (r_state == S_SQR && i_status.exp_msb) begin
                        o_cmd.start = 1'b1;
                        o_cmd.op    = mexp_pkg::OP_MULT;
                        n_state     = S_MUL;
                    end else if (r_bit == '0) begin
                        n_state = S_OUT;
                    end else begin
                        o_cmd.shift_exp = 1'b1;
                        o_cmd.start     = 1'b1;
                        n_bit           = r_bit - mexp_pkg::CNT_W'(1);
                        n_state         = S_SQR;
                    end
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

endmodule

// ----- rtl/mexp_checker.sv -----
// Port checker of the modular exponentiation block, bound to the top level.
// Depends on mexp_pkg and modular_exponentiation_macros.svh.
`include "modular_exponentiation_macros.svh"

module mexp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [mexp_pkg::IN_TDATA_W-1:0] s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mexp_pkg::DATA_W-1:0]     m_tdata
);

    logic unused_in;
    assign unused_in = ^s_tdata;

    `MEXP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
    `MEXP_ASSERT_NEVER(a_one_in_flight, m_tvalid && s_tready, "input taken while a result waits")
    `MEXP_ASSERT(a_no_instant_result, s_tvalid && s_tready |=> !m_tvalid, "result shown right after accept")

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/power_checker.sv -----
// Checker for the modular exponentiation block: watches both stream channels,
// computes each expected power and compares it with the result. Uses mexp_pkg.
module power_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [mexp_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mexp_pkg::DATA_W-1:0]     m_tdata,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0] power_queue[$];

    function automatic logic [63:0] mul_reduce(logic [63:0] x, logic [63:0] y,
                                               logic [63:0] m);
        logic [127:0] prod;
        prod = {64'd0, x} * {64'd0, y};
        return 64'(prod % {64'd0, m});
    endfunction

    function automatic logic [63:0] compute_power(logic [62:0] b, logic [62:0] e,
                                                  logic [62:0] m);
        logic [63:0] acc;
        logic [63:0] mm;
        mm = {1'b0, m};
        if (e == 0) return 64'd1;
        if (m != 0) begin
            acc = 64'd1 % mm;
            for (int i = 62; i >= 0; i--) begin
                acc = mul_reduce(acc, acc, mm);
                if (e[i]) acc = mul_reduce(acc, {1'b0, b}, mm);
            end
        end else begin
            acc = 64'd1;
            for (int i = 62; i >= 0; i--) begin
                acc = acc * acc;
                if (e[i]) acc = acc * {1'b0, b};
            end
        end
        return acc;
    endfunction

    assign o_pending = power_queue.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        logic [63:0] want;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                power_queue.push_back(compute_power(s_tdata[62:0], s_tdata[125:63],
                                                    s_tdata[188:126]));
            end
            if (m_tvalid && m_tready) begin
                if (power_queue.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = power_queue.pop_front();
                    if (want !== m_tdata) begin
                        $display("%0t: power_result mismatch, expected %h, actual %h",
                                 $time, want, m_tdata);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- tb/testbench.sv -----
// Top of the modular exponentiation testbench: clock, reset, directed and random
// stimulus with random gaps, and the verdict. Uses mexp_pkg and power_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic                            i_clk = 0;
    logic                            i_rst_n = 0;
    logic                            s_tvalid = 0;
    logic                            s_tready;
    logic [mexp_pkg::IN_TDATA_W-1:0] s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 0;
    logic [mexp_pkg::DATA_W-1:0]     m_tdata;
    int                              fail_count;
    int                              pending;
    bit                              sending_done = 0;

    localparam logic [62:0] MAX63 = {63{1'b1}};

    always #6 i_clk = ~i_clk;

    modular_exponentiation dut (.*);

    power_checker checker_inst (.*, .o_fail_count(fail_count), .o_pending(pending));

    function automatic logic [62:0] rand63();
        return 63'({$urandom(), $urandom()});
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
    endfunction

    task automatic send_item(logic [62:0] b, logic [62:0] e, logic [62:0] m);
        int gap;
        gap = gap_len();
        repeat (gap) @(posedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata <= {3'd0, m, e, b};
        do @(posedge i_clk); while (!s_tready);
        s_tvalid <= 1'b0;
    endtask

    // Receiver: one long hold-off early on, then random stalls.
    initial begin
        @(posedge i_clk iff i_rst_n);
        repeat (40000) @(posedge i_clk);
        forever begin
            m_tready <= 1'b1;
            @(posedge i_clk);
            if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (gap_len()) @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [62:0] b;
        logic [62:0] e;
        logic [62:0] m;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_item(63'd5, 63'd0, 63'd7);
        send_item(63'd5, 63'd0, 63'd1);
        send_item(63'd0, 63'd0, 63'd0);
        send_item(MAX63, 63'd0, MAX63);
        send_item(63'd123, 63'd45, 63'd1);
        send_item(63'd0, 63'd17, 63'd1000);
        send_item(63'd0, 63'd17, 63'd0);
        send_item(63'd0, MAX63, MAX63);
        send_item(63'd3, 63'd200, 63'd0);
        send_item(MAX63, MAX63, 63'd0);
        send_item(MAX63, MAX63, MAX63);
        send_item(MAX63, MAX63, MAX63 - 63'd1);
        send_item(63'd2, 63'd62, 63'd0);
        send_item(63'd2, 63'd64, 63'd0);
        send_item(MAX63 - 63'd1, 63'd2, MAX63);
        send_item(63'd1, MAX63, 63'd97);
        send_item(63'd4, 63'd13, 63'd497);
        send_item(MAX63, 63'd1, 63'd0);
        send_item(MAX63, 63'd1, 63'd2);
        for (int n = 0; n < 100; n++) begin
            b = rand63();
            e = rand63();
            m = rand63();
            case ($urandom_range(0, 5))
                0: m = '0;
                1: m = 63'($urandom_range(1, 20));
                2: e = 63'($urandom_range(0, 40));
                3: b = 63'($urandom_range(0, 3));
                default: ;
            endcase
            send_item(b, e, m);
        end
        sending_done = 1;
    end

    initial begin
        wait (sending_done);
        repeat (2) @(posedge i_clk);
        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(12ns * 12000000);
        $display("Some tests failed");
        $finish;
    end
endmodule
